// ===== rtl/core/ocv_soc_estimator_defines.svh =====
// Assertion macros shared by the state of charge estimator RTL.
// No dependencies; expects clk and rst_n in the scope of use.
`ifndef OCV_SOC_ESTIMATOR_DEFINES_SVH
`define OCV_SOC_ESTIMATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define OCV_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ocv_soc_estimator: assertion failed");

// Next-cycle implication, disabled during reset
`define OCV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ocv_soc_estimator: assertion failed");

`endif

// ===== rtl/core/ocv_pkg.sv =====
// Shared types, constants and the open-circuit voltage ROM of the estimator.
// No dependencies.
`default_nettype none

package ocv_pkg;

  localparam int VD_W     = 19;  // pack voltage times 100, in mV
  localparam int CC_W     = 8;   // cell count
  localparam int MAG_W    = 24;  // magnitude of resistance times current
  localparam int CD_W     = 14;  // parallel cells times 1000
  localparam int V_W      = 16;  // cell voltage in mV
  localparam int SOC_W    = 7;
  localparam int ROM_SIZE = 100;
  localparam int QDEPTH   = 2;

  // Configuration register indexes
  localparam logic [1:0] CFG_CELL_COUNT = 2'd0;
  localparam logic [1:0] CFG_RESISTANCE = 2'd1;
  localparam logic [1:0] CFG_PARALLEL   = 2'd2;

  // One classified measurement waiting for the back end
  typedef struct packed {
    logic [VD_W-1:0]  volt_dividend;
    logic [CC_W-1:0]  cell_count;
    logic [MAG_W-1:0] cur_mag;
    logic             cur_neg;
    logic [CD_W-1:0]  comp_divisor;
  } q_entry_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Open-circuit cell voltage in mV; entry i stands for i+1 percent
  function automatic logic [V_W-1:0] ocv_rom_val(input logic [7:0] idx);
    logic [V_W-1:0] v;
    unique case (idx)
      8'd0:  v = 16'd2647;  8'd1:  v = 16'd2754;  8'd2:  v = 16'd2837;
      8'd3:  v = 16'd2902;  8'd4:  v = 16'd2948;  8'd5:  v = 16'd2985;
      8'd6:  v = 16'd3012;  8'd7:  v = 16'd3035;  8'd8:  v = 16'd3052;
      8'd9:  v = 16'd3068;  8'd10: v = 16'd3081;  8'd11: v = 16'd3092;
      8'd12: v = 16'd3100;  8'd13: v = 16'd3108;  8'd14: v = 16'd3115;
      8'd15: v = 16'd3123;  8'd16: v = 16'd3130;  8'd17: v = 16'd3136;
      8'd18: v = 16'd3142;  8'd19: v = 16'd3148;  8'd20: v = 16'd3152;
      8'd21: v = 16'd3156;  8'd22: v = 16'd3160;  8'd23: v = 16'd3164;
      8'd24: v = 16'd3168;  8'd25: v = 16'd3172;  8'd26: v = 16'd3175;
      8'd27: v = 16'd3177;  8'd28: v = 16'd3179;  8'd29: v = 16'd3182;
      8'd30: v = 16'd3184;  8'd31: v = 16'd3186;  8'd32: v = 16'd3188;
      8'd33: v = 16'd3190;  8'd34: v = 16'd3193;  8'd35: v = 16'd3195;
      8'd36: v = 16'd3197;  8'd37: v = 16'd3199;  8'd38: v = 16'd3201;
      8'd39: v = 16'd3202;  8'd40: v = 16'd3204;  8'd41: v = 16'd3205;
      8'd42: v = 16'd3207;  8'd43: v = 16'd3208;  8'd44: v = 16'd3210;
      8'd45: v = 16'd3211;  8'd46: v = 16'd3212;  8'd47: v = 16'd3214;
      8'd48: v = 16'd3215;  8'd49: v = 16'd3216;  8'd50: v = 16'd3217;
      8'd51: v = 16'd3218;  8'd52: v = 16'd3219;  8'd53: v = 16'd3220;
      8'd54: v = 16'd3221;  8'd55: v = 16'd3223;  8'd56: v = 16'd3224;
      8'd57: v = 16'd3225;  8'd58: v = 16'd3227;  8'd59: v = 16'd3228;
      8'd60: v = 16'd3229;  8'd61: v = 16'd3230;  8'd62: v = 16'd3231;
      8'd63: v = 16'd3232;  8'd64: v = 16'd3233;  8'd65: v = 16'd3235;
      8'd66: v = 16'd3236;  8'd67: v = 16'd3237;  8'd68: v = 16'd3238;
      8'd69: v = 16'd3240;  8'd70: v = 16'd3241;  8'd71: v = 16'd3243;
      8'd72: v = 16'd3244;  8'd73: v = 16'd3246;  8'd74: v = 16'd3247;
      8'd75: v = 16'd3248;  8'd76: v = 16'd3249;  8'd77: v = 16'd3250;
      8'd78: v = 16'd3251;  8'd79: v = 16'd3252;  8'd80: v = 16'd3254;
      8'd81: v = 16'd3256;  8'd82: v = 16'd3258;  8'd83: v = 16'd3259;
      8'd84: v = 16'd3260;  8'd85: v = 16'd3261;  8'd86: v = 16'd3262;
      8'd87: v = 16'd3264;  8'd88: v = 16'd3265;  8'd89: v = 16'd3266;
      8'd90: v = 16'd3267;  8'd91: v = 16'd3268;  8'd92: v = 16'd3270;
      8'd93: v = 16'd3271;  8'd94: v = 16'd3272;  8'd95: v = 16'd3273;
      8'd96: v = 16'd3274;  8'd97: v = 16'd3279;  8'd98: v = 16'd3312;
      8'd99: v = 16'd3649;
      default: v = 16'hFFFF;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ocv_fifo.sv =====
// Two-entry queue of classified measurements between front and back end.
// Depends on ocv_pkg.
`default_nettype none

module ocv_fifo (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push,
  input  ocv_pkg::q_entry_t wr_entry,
  input  wire              pop,
  output ocv_pkg::q_entry_t rd_entry,
  output ocv_pkg::q_stat_t  stat
);
  import ocv_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  q_entry_t        mem_r [QDEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]     count_r, count_nxt;
  logic            do_push, do_pop;

  assign stat.full  = (count_r == (PW+1)'(QDEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_entry   = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QDEPTH-1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QDEPTH-1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + (PW+1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entry payload
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ocv_front.sv =====
// Front end: configuration registers, input acceptance and operand set-up.
// Depends on ocv_pkg; feeds ocv_fifo.
`default_nettype none

module ocv_front (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               cfg_we,
  input  wire  [1:0]        cfg_index,
  input  wire  [7:0]        cfg_wdata,
  input  wire               in_tvalid,
  output logic              in_tready,
  input  wire  [31:0]       in_tdata,
  input  ocv_pkg::q_stat_t  q_stat,
  output logic              q_push,
  output ocv_pkg::q_entry_t q_entry
);
  import ocv_pkg::*;

  logic [CC_W-1:0]     cell_count_r;
  logic [7:0]          resistance_r;
  logic [3:0]          parallel_r;
  logic [11:0]         volt;
  logic signed [15:0]  cur;
  logic signed [24:0]  prod;
  logic [3:0]          par_eff;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_count_r <= 8'd80;
      resistance_r <= 8'd9;
      parallel_r   <= 4'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CELL_COUNT: cell_count_r <= cfg_wdata;
        CFG_RESISTANCE: resistance_r <= cfg_wdata;
        CFG_PARALLEL:   parallel_r   <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  assign volt = in_tdata[11:0];
  assign cur  = $signed(in_tdata[27:12]);

  // IR drop numerator; split into magnitude and sign for the unsigned divider
  assign prod    = $signed({1'b0, resistance_r}) * cur;
  assign par_eff = (parallel_r == 4'd0) ? 4'd1 : parallel_r;

  assign in_tready = !q_stat.full;
  assign q_push    = in_tvalid && in_tready;

  // Both truncating divisions fold into one by parallel cells times 1000
  always_comb begin
    q_entry.volt_dividend = VD_W'(volt) * VD_W'(100);
    q_entry.cell_count    = cell_count_r;
    q_entry.cur_neg       = prod[24];
    q_entry.cur_mag       = prod[24] ? MAG_W'(-prod) : prod[MAG_W-1:0];
    q_entry.comp_divisor  = CD_W'(par_eff) * CD_W'(1000);
  end

endmodule

`default_nettype wire

// ===== rtl/core/ocv_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// No dependencies.
`default_nettype none

module ocv_div #(
  parameter int NW = 24,
  parameter int DW = 14
) (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           start,
  input  wire  [NW-1:0] dividend,
  input  wire  [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);

  localparam int CW = $clog2(NW+1);

  logic [DW-1:0] rem_r, rem_nxt;
  logic [NW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] dvs_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   rem_sh;
  logic [DW-1:0] rem_sub;
  logic          sub_ok;

  // Shift in the next dividend bit and trial-subtract. A zero divisor
  // always subtracts and leaves an all-ones quotient.
  assign rem_sh  = {rem_r, quo_r[NW-1]};
  assign sub_ok  = (rem_sh >= {1'b0, dvs_r});
  assign rem_sub = rem_sh[DW-1:0] - dvs_r;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    done_nxt = done_r;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = CW'(NW);
      done_nxt = 1'b0;
    end else if (cnt_r != '0) begin
      if (sub_ok) begin
        rem_nxt = rem_sub;
        quo_nxt = {quo_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DW-1:0];
        quo_nxt = {quo_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ===== rtl/core/ocv_back.sv =====
// Back end: divisions, IR compensation, binary search of the ROM and result.
// Depends on ocv_pkg, ocv_div and ocv_soc_estimator_defines.svh.
`default_nettype none
`include "ocv_soc_estimator_defines.svh"

module ocv_back #(
  parameter int TABLE_ENTRIES = 100
) (
  input  wire               clk,
  input  wire               rst_n,
  input  ocv_pkg::q_stat_t  q_stat,
  input  ocv_pkg::q_entry_t q_entry,
  output logic              q_pop,
  output logic              out_tvalid,
  input  wire               out_tready,
  output logic [7:0]        out_tdata,
  output logic              out_tuser
);
  import ocv_pkg::*;

  localparam int LIMIT = (TABLE_ENTRIES > ROM_SIZE) ? ROM_SIZE : TABLE_ENTRIES;
  localparam int NBW   = $clog2(LIMIT+1);
  localparam int SW    = (NBW > 1) ? $clog2(NBW) : 1;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_SRCH, S_OUT} state_t;

  state_t           state_r;
  logic [NBW-1:0]   n_r;
  logic [SW-1:0]    step_r;
  logic [V_W-1:0]   v_r;
  logic             neg_r;
  logic [SOC_W-1:0] soc_r;
  logic [SOC_W-1:0] out_soc_r;
  logic             out_hit_r;
  logic             out_valid_r;

  logic             start;
  logic             v_done, c_done;
  logic [VD_W-1:0]  v_quo;
  logic [MAG_W-1:0] c_quo;
  logic [V_W-1:0]   comp16;
  logic [V_W-1:0]   v_nxt;
  logic [NBW-1:0]   cand;
  logic [7:0]       rom_idx;
  logic             cand_ok;
  logic             load_out;
  logic             n_hit;

  assign start = (state_r == S_IDLE) && !q_stat.empty;
  assign q_pop = start;

  // Average cell voltage: pack voltage times 100 over cell count
  ocv_div #(.NW(VD_W), .DW(CC_W)) u_div_volt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .dividend (q_entry.volt_dividend),
    .divisor  (q_entry.cell_count),
    .done     (v_done),
    .quotient (v_quo)
  );

  // IR compensation magnitude
  ocv_div #(.NW(MAG_W), .DW(CD_W)) u_div_comp (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .dividend (q_entry.cur_mag),
    .divisor  (q_entry.comp_divisor),
    .done     (c_done),
    .quotient (c_quo)
  );

  // Restore sign, subtract and wrap at 16 bits
  assign comp16 = neg_r ? (V_W'(0) - c_quo[V_W-1:0]) : c_quo[V_W-1:0];
  assign v_nxt  = v_quo[V_W-1:0] - comp16;

  // The table rises strictly, so the answer is the count of entries at or
  // below the voltage; build that count one bit a cycle, top bit first
  assign cand    = n_r | (NBW'(1) << step_r);
  assign rom_idx = 8'(cand) - 8'd1;
  assign cand_ok = (cand <= NBW'(LIMIT)) && (ocv_rom_val(rom_idx) <= v_r);

  assign load_out = (state_r == S_OUT) && (!out_valid_r || out_tready);
  assign n_hit    = (n_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      soc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (v_done && c_done) begin
            state_r <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (step_r == '0) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          // Hold the result until the output slot is free
          if (load_out) begin
            out_valid_r <= 1'b1;
            out_hit_r   <= n_hit;
            if (n_hit) begin
              soc_r     <= SOC_W'(n_r);
              out_soc_r <= SOC_W'(n_r);
            end else begin
              out_soc_r <= soc_r;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= q_entry.cur_neg;
    end
    if (state_r == S_DIV && v_done && c_done) begin
      v_r    <= v_nxt;
      n_r    <= '0;
      step_r <= SW'(NBW-1);
    end
    if (state_r == S_SRCH) begin
      if (cand_ok) begin
        n_r <= cand;
      end
      if (step_r != '0) begin
        step_r <= step_r - SW'(1);
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_soc_r};
  assign out_tuser  = out_hit_r;

  `OCV_ASSERT_IMPL(a_soc_range, 1'b1, soc_r <= SOC_W'(LIMIT))
  `OCV_ASSERT_NEXT(a_soc_held, load_out && !n_hit, out_soc_r == $past(soc_r))
  `OCV_ASSERT_IMPL(a_div_ready, state_r == S_SRCH, v_done && c_done)
  `OCV_ASSERT_IMPL(a_hit_nonzero, out_valid_r && out_hit_r, out_soc_r != '0)

endmodule

`default_nettype wire

// ===== rtl/core/ocv_soc_estimator.sv =====
// Top level of the open-circuit voltage state of charge estimator.
// Depends on ocv_pkg, ocv_front, ocv_fifo and ocv_back.
//
//   channel  | direction | handshake        | payload
//   ---------+-----------+------------------+----------------------------------
//   in_      | sink      | tvalid / tready  | tdata: voltage[11:0], current[27:12]
//   out_     | source    | tvalid / tready  | tdata: soc[6:0]; tuser: table_hit
//   cfg_     | sink      | we, no wait      | index 0..2, 8-bit write data
//
// An item leaves the queue, passes through the two restoring dividers
// running side by side (the 24-bit IR drop division is the longer one),
// takes seven binary-search steps over the voltage ROM and loads the
// output register. The front takes further items into a two-entry queue
// while the back works. Reset is synchronous and active low; state of
// charge restarts at 0. A stalled output holds the back end in its last
// state; the queue then fills and in_tready falls.
`default_nettype none

module ocv_soc_estimator #(
  parameter int TABLE_ENTRIES = 100
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_index,
  input  wire  [7:0]  cfg_wdata,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [31:0] in_tdata,   // pack_voltage_100mv[11:0], pack_current_ma[27:12]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [7:0]  out_tdata,  // state_of_charge[6:0]
  output logic        out_tuser   // table_hit[0]
);
  import ocv_pkg::*;

  q_stat_t  q_stat;
  q_entry_t wr_entry;
  q_entry_t rd_entry;
  logic     q_push;
  logic     q_pop;

  ocv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_entry   (wr_entry)
  );

  ocv_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (wr_entry),
    .pop      (q_pop),
    .rd_entry (rd_entry),
    .stat     (q_stat)
  );

  ocv_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_entry    (rd_entry),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire
